// ----- rtl/cnm_pkg.sv -----
// Shared types and constants for the cross neighbour morphology block.
package cnm_pkg;

    localparam int CNM_MAX_WIDTH  = 1024;
    localparam int CNM_MAX_HEIGHT = 1024;
    localparam int CNM_OUT_DEPTH  = 4;

    localparam logic        MODE_RESET      = 1'b0;
    localparam logic [10:0] WIDTH_RESET     = 11'd640;
    localparam logic [10:0] HEIGHT_RESET    = 11'd480;
    localparam logic [7:0]  HIGH_THR_RESET  = 8'd250;
    localparam logic [7:0]  LOW_THR_RESET   = 8'd5;
    localparam logic [10:0] MIN_SIZE        = 11'd3;

    localparam logic [7:0]  PIX_WHITE = 8'd255;
    localparam logic [7:0]  PIX_BLACK = 8'd0;

    localparam logic        MODE_GROW   = 1'b0;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_WIDTH    = 3'd1,
        REG_HEIGHT   = 3'd2,
        REG_HIGH_THR = 3'd3,
        REG_LOW_THR  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] pixel;
        logic       border;
        logic       eof;
        logic       last;
    } result_t;

endpackage

// ----- rtl/cnm_out_fifo.sv -----
// Result queue taking up to two results per cycle and releasing one.
module cnm_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  cnm_pkg::result_t push_a,
    input  cnm_pkg::result_t push_b,
    input  logic             pop,
    output logic             valid,
    output cnm_pkg::result_t head,
    output logic [$clog2(cnm_pkg::CNM_OUT_DEPTH+1)-1:0] count
);
    import cnm_pkg::*;

    localparam int PW = $clog2(CNM_OUT_DEPTH);
    localparam int NW = $clog2(CNM_OUT_DEPTH + 1);

    result_t        mem [CNM_OUT_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [NW-1:0]  count_reg;
    logic [NW-1:0]  count_next;
    logic           do_pop;

    assign valid  = (count_reg != '0);
    assign head   = mem[rd_ptr_reg];
    assign count  = count_reg;
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PW'(do_pop);
        count_next  = count_reg + NW'(push_cnt) - NW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + PW'(1)] <= push_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg + NW'(push_cnt)) <= NW'(CNM_OUT_DEPTH) + NW'(do_pop))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        !valid |-> !do_pop)
        else $error("pop from empty result queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd0 && !do_pop) |=> $stable(count_reg))
        else $error("queue count moved without traffic");

endmodule

// ----- rtl/cross_neighbour_morphology.sv -----
// Top level of the streaming four-neighbour cross morphology block.
// Takes one 8-bit pixel per clock in raster order while in_stall is low and returns the
// result for the pixel one row above, so results trail the input by one row; rows other
// than the first give one result per input and the last row gives two (the delayed
// result, then the input itself as a border pixel). Two line stores hold the two previous
// rows in simple dual-port memories (one read port, one write port) with a registered
// read; each input reads both stores when accepted and writes them back in the next cycle,
// giving a sustained rate of one pixel per clock on all rows but the last while the output
// is not stalled; on the last row the output drains one result per unstalled clock and the
// two results per input make the input stall. A result caused by an input passes through
// the stage-two registers and the four-entry result queue before it can be taken; the
// queue decouples the output stall from the input. Writing image_width or image_height
// restarts the frame at its first pixel; the line stores need no clearing pass.
module cross_neighbour_morphology #(
    parameter int MAX_WIDTH  = cnm_pkg::CNM_MAX_WIDTH,
    parameter int MAX_HEIGHT = cnm_pkg::CNM_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_pixel,
    output logic        is_border,
    output logic        end_of_frame,
    output logic        last_of_run
);
    import cnm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int NW = $clog2(CNM_OUT_DEPTH + 1);

    logic        mode_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [7:0]  high_thr_reg;
    logic [7:0]  low_thr_reg;

    logic        cfg_wr;
    logic        size_wr;
    cfg_reg_t    cfg_sel;

    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    logic          in_accept;
    logic [1:0]    new_nres;
    logic [CW-1:0] right_addr;

    logic [7:0]    prev_mem [MAX_WIDTH];
    logic [7:0]    sprev_mem [MAX_WIDTH];
    logic [7:0]    prev_rd_reg;
    logic [7:0]    sprev_rd_reg;

    logic          s2_valid_reg;
    logic [1:0]    s2_nres_reg;
    logic [CW-1:0] s2_col_reg;
    logic          s2_border_reg;
    logic          s2_last_row_reg;
    logic          s2_col_last_reg;
    logic [7:0]    s2_pixel_reg;

    logic [7:0]    centre_reg;
    logic [7:0]    left_reg;

    logic          hi_hit;
    logic          lo_hit;
    logic [7:0]    cross_val;
    result_t       res_a;
    result_t       res_b;
    logic [1:0]    push_cnt;

    logic          q_valid;
    result_t       q_head;
    logic [NW-1:0] q_count;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[4:2]);
    assign size_wr = cfg_wr && (cfg_sel == REG_WIDTH || cfg_sel == REG_HEIGHT);

    always_comb
    begin
        unique case (cfg_sel)
            REG_MODE:     prdata = {31'd0, mode_reg};
            REG_WIDTH:    prdata = {21'd0, width_reg};
            REG_HEIGHT:   prdata = {21'd0, height_reg};
            REG_HIGH_THR: prdata = {24'd0, high_thr_reg};
            REG_LOW_THR:  prdata = {24'd0, low_thr_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            high_thr_reg <= HIGH_THR_RESET;
            low_thr_reg  <= LOW_THR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_MODE:     mode_reg     <= pwdata[0];
                REG_WIDTH:    width_reg    <= pwdata[10:0];
                REG_HEIGHT:   height_reg   <= pwdata[10:0];
                REG_HIGH_THR: high_thr_reg <= pwdata[7:0];
                REG_LOW_THR:  low_thr_reg  <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    // saturate frame size
    always_comb
    begin
        if (width_reg < MIN_SIZE)
            last_col = CW'(MIN_SIZE - 11'd1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            last_col = CW'(MAX_WIDTH - 1);
        else
            last_col = CW'(width_reg - 11'd1);

        if (height_reg < MIN_SIZE)
            last_row = RW'(MIN_SIZE - 11'd1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            last_row = RW'(MAX_HEIGHT - 1);
        else
            last_row = RW'(height_reg - 11'd1);
    end

    // input admission against queue room
    always_comb
    begin
        if (row_reg == '0)
            new_nres = 2'd0;
        else if (row_reg == last_row)
            new_nres = 2'd2;
        else
            new_nres = 2'd1;
    end

    assign in_stall  = ((3'(q_count) + 3'(s2_nres_reg) + 3'(new_nres))
                        > 3'(CNM_OUT_DEPTH));
    assign in_accept = in_valid && !in_stall;

    // raster position
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (size_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // prefetch the right neighbour; at row end fetch column 0 for the next row
    assign right_addr = (col_reg == last_col) ? '0 : col_reg + CW'(1);

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            prev_rd_reg  <= prev_mem[right_addr];
            sprev_rd_reg <= sprev_mem[col_reg];
        end
        if (s2_valid_reg)
        begin
            prev_mem[s2_col_reg]  <= s2_pixel_reg;
            sprev_mem[s2_col_reg] <= centre_reg;
        end
    end

    // stage two control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_nres_reg  <= 2'd0;
        end
        else
        begin
            s2_valid_reg <= in_accept;
            s2_nres_reg  <= in_accept ? new_nres : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s2_col_reg      <= col_reg;
            s2_pixel_reg    <= in_pixel;
            s2_border_reg   <= (row_reg == RW'(1)) || (col_reg == '0) || (col_reg == last_col);
            s2_last_row_reg <= (row_reg == last_row);
            s2_col_last_reg <= (col_reg == last_col);
        end
        if (s2_valid_reg)
        begin
            centre_reg <= prev_rd_reg;
            left_reg   <= centre_reg;
        end
    end

    // cross rule
    always_comb
    begin
        hi_hit = (sprev_rd_reg > high_thr_reg) || (left_reg > high_thr_reg) ||
                 (prev_rd_reg > high_thr_reg) || (s2_pixel_reg > high_thr_reg);
        lo_hit = (sprev_rd_reg < low_thr_reg) || (left_reg < low_thr_reg) ||
                 (prev_rd_reg < low_thr_reg) || (s2_pixel_reg < low_thr_reg);
        if (mode_reg == MODE_GROW)
            cross_val = hi_hit ? PIX_WHITE : PIX_BLACK;
        else
            cross_val = lo_hit ? PIX_BLACK : PIX_WHITE;

        res_a.pixel  = s2_border_reg ? centre_reg : cross_val;
        res_a.border = s2_border_reg;
        res_a.eof    = 1'b0;
        res_a.last   = !s2_last_row_reg;

        res_b.pixel  = s2_pixel_reg;
        res_b.border = 1'b1;
        res_b.eof    = s2_col_last_reg;
        res_b.last   = 1'b1;
    end

    assign push_cnt = s2_valid_reg ? s2_nres_reg : 2'd0;

    cnm_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push_a   (res_a),
        .push_b   (res_b),
        .pop      (!out_stall),
        .valid    (q_valid),
        .head     (q_head),
        .count    (q_count)
    );

    assign out_valid    = q_valid;
    assign out_pixel    = q_head.pixel;
    assign is_border    = q_head.border;
    assign end_of_frame = q_head.eof;
    assign last_of_run  = q_head.last;

    assert property (@(posedge clk) disable iff (!rst_n)
        (3'(q_count) + 3'(s2_nres_reg)) <= 3'(CNM_OUT_DEPTH))
        else $error("results in flight exceed queue room");

    assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col)
        else $error("column beyond row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !size_wr && col_reg == last_col) |=> (col_reg == '0))
        else $error("column did not wrap at row end");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s2_nres_reg == 2'd2) |-> s2_last_row_reg)
        else $error("second result outside last row");

endmodule

// ----- test/cross_neighbour_morphology_tb.sv -----
// Self-checking testbench for the cross neighbour morphology streaming block.
`timescale 1ns / 100ps

module cross_neighbour_morphology_tb;

    import cnm_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 9;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          RANDOM_ITEMS  = 560;
    localparam int          WIDEST_EXTRA  = 120;
    localparam int          MAX_REPORTS   = 10;
    localparam int unsigned LIMIT_CYCLES  = 500000;
    localparam logic        MODE_SHRINK   = ~MODE_GROW;

    // first pixel in the top byte
    localparam logic [71:0] FRAME_GROW   = {8'd255, 8'd0,   8'd255,
                                            8'd0,   8'd7,   8'd0,
                                            8'd255, 8'd254, 8'd255};
    localparam logic [71:0] FRAME_SHRINK = {8'd255, 8'd254, 8'd255,
                                            8'd255, 8'd128, 8'd255,
                                            8'd1,   8'd255, 8'd0};

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_pixel;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_pixel;
    logic        is_border;
    logic        end_of_frame;
    logic        last_of_run;

    // predictor state
    logic        cfg_mode;
    logic [10:0] cfg_width;
    logic [10:0] cfg_height;
    logic [7:0]  cfg_high;
    logic [7:0]  cfg_low;
    logic [7:0]  line_prev  [CNM_MAX_WIDTH];
    logic [7:0]  line_prev2 [CNM_MAX_WIDTH];
    int unsigned pos_col;
    int unsigned pos_row;
    result_t     pending_results [$];

    result_t      expected_res;
    result_t      actual_res;
    int           mismatch_count;
    int           sent_count;
    int           burst_left;
    bit           no_gaps;
    bit           hold_request;
    int           hold_left;
    int           style_left;
    stall_style_t stall_style;
    int unsigned  cycle_count;

    cross_neighbour_morphology u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_pixel     (in_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_pixel    (out_pixel),
        .is_border    (is_border),
        .end_of_frame (end_of_frame),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("cross_neighbour_morphology verification failed");
            $finish;
        end
    end

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    function automatic int unsigned sat_size(input logic [10:0] v, input int unsigned maxv);
        if (v < MIN_SIZE)
        begin
            return int'(MIN_SIZE);
        end
        if (v > maxv)
        begin
            return maxv;
        end
        return int'(v);
    endfunction

    function automatic logic [31:0] reg_value(input cfg_reg_t idx);
        case (idx)
            REG_MODE:     return 32'(cfg_mode);
            REG_WIDTH:    return 32'(cfg_width);
            REG_HEIGHT:   return 32'(cfg_height);
            REG_HIGH_THR: return 32'(cfg_high);
            default:      return 32'(cfg_low);
        endcase
    endfunction

    function automatic void morph_predict(input logic [7:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic        on_edge;
        logic [7:0]  up;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [7:0]  val;
        result_t     res;
        w = sat_size(cfg_width, CNM_MAX_WIDTH);
        h = sat_size(cfg_height, CNM_MAX_HEIGHT);
        c = pos_col;
        r = pos_row;
        if (c >= w)
        begin
            c = w - 1;
        end
        if (r >= h)
        begin
            r = h - 1;
        end
        if (r >= 1)
        begin
            on_edge = (r == 1) || (c == 0) || (c == w - 1);
            if (on_edge)
            begin
                val = line_prev[c];
            end
            else
            begin
                up    = line_prev2[c];
                left  = line_prev2[c - 1];
                right = line_prev[c + 1];
                if (cfg_mode == MODE_GROW)
                begin
                    val = (up > cfg_high || left > cfg_high || right > cfg_high ||
                           px > cfg_high) ? PIX_WHITE : PIX_BLACK;
                end
                else
                begin
                    val = (up < cfg_low || left < cfg_low || right < cfg_low ||
                           px < cfg_low) ? PIX_BLACK : PIX_WHITE;
                end
            end
            res.pixel  = val;
            res.border = on_edge;
            res.eof    = 1'b0;
            res.last   = (r != h - 1);
            pending_results.push_back(res);
            if (r == h - 1)
            begin
                res.pixel  = px;
                res.border = 1'b1;
                res.eof    = (c == w - 1);
                res.last   = 1'b1;
                pending_results.push_back(res);
            end
        end
        line_prev2[c] = line_prev[c];
        line_prev[c]  = px;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        pos_col = c;
        pos_row = r;
    endfunction

    function automatic logic [7:0] pick_pixel();
        int          v;
        logic [7:0]  thr;
        thr = (cfg_mode == MODE_GROW) ? cfg_high : cfg_low;
        case ($urandom_range(0, 7)) inside
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? PIX_WHITE : PIX_BLACK;
            [6:7]:
            begin
                v = int'(thr) + int'($urandom_range(0, 4)) - 2;
                if (v < 0)
                begin
                    v = 0;
                end
                if (v > 255)
                begin
                    v = 255;
                end
                return 8'(v);
            end
            default:
            begin
                // quiet side of the active threshold
                if (cfg_mode == MODE_GROW)
                begin
                    return 8'($urandom_range(0, cfg_high));
                end
                return 8'($urandom_range(cfg_low, 255));
            end
        endcase
    endfunction

    task automatic read_check(input cfg_reg_t idx);
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== reg_value(idx))
        begin
            log_mismatch($sformatf("register %s read exp 0x%0h act 0x%0h",
                                   idx.name(), reg_value(idx), got));
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:     cfg_mode = value[0];
            REG_WIDTH:
            begin
                cfg_width = value[10:0];
                pos_col   = 0;
                pos_row   = 0;
            end
            REG_HEIGHT:
            begin
                cfg_height = value[10:0];
                pos_col    = 0;
                pos_row    = 0;
            end
            REG_HIGH_THR: cfg_high = value[7:0];
            default:      cfg_low = value[7:0];
        endcase
        read_check(idx);
    endtask

    task automatic send_pixel(input logic [7:0] px);
        if (!no_gaps && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        in_valid <= 1'b1;
        in_pixel <= px;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        morph_predict(px);
        sent_count++;
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: stall patterns plus an occasional long hold-off
    initial
    begin
        out_stall   <= 1'b0;
        hold_left   = 0;
        style_left  = 0;
        stall_style = STALL_NONE;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    stall_style = stall_style_t'($urandom_range(0, 3));
                    style_left  = $urandom_range(20, 200);
                end
                style_left--;
                case (stall_style)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ((style_left % 5) < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            actual_res = '{out_pixel, is_border, end_of_frame, last_of_run};
            if (pending_results.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result pixel %0d border %0b eof %0b last %0b",
                                       out_pixel, is_border, end_of_frame, last_of_run));
            end
            else
            begin
                expected_res = pending_results.pop_front();
                if (actual_res !== expected_res)
                begin
                    log_mismatch($sformatf(
                        "exp pixel %0d border %0b eof %0b last %0b / act pixel %0d border %0b eof %0b last %0b",
                        expected_res.pixel, expected_res.border, expected_res.eof,
                        expected_res.last, out_pixel, is_border, end_of_frame, last_of_run));
                end
            end
        end
    end

    task automatic test_reset_values();
        read_check(REG_MODE);
        read_check(REG_WIDTH);
        read_check(REG_HEIGHT);
        read_check(REG_HIGH_THR);
        read_check(REG_LOW_THR);
    endtask

    task automatic test_saturated_grow_frame();
        wait_until_drained();
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_HEIGHT, 32'd2);
        write_reg(REG_MODE, 32'(MODE_GROW));
        write_reg(REG_HIGH_THR, 32'd254);
        write_reg(REG_LOW_THR, 32'd0);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel(FRAME_GROW[8 * (8 - i) +: 8]);
        end
    endtask

    task automatic test_restart_shrink_frame();
        // cut a frame short, then restart it by a size write
        for (int i = 0; i < 4; i++)
        begin
            send_pixel(pick_pixel());
        end
        wait_until_drained();
        write_reg(REG_WIDTH, 32'd3);
        write_reg(REG_MODE, 32'(MODE_SHRINK));
        write_reg(REG_LOW_THR, 32'd255);
        for (int i = 0; i < 9; i++)
        begin
            send_pixel(FRAME_SHRINK[8 * (8 - i) +: 8]);
        end
    endtask

    task automatic test_backpressure();
        wait_until_drained();
        write_reg(REG_WIDTH, 32'd8);
        write_reg(REG_HEIGHT, 32'd6);
        write_reg(REG_HIGH_THR, 32'd128);
        write_reg(REG_LOW_THR, 32'd128);
        no_gaps = 1'b1;
        for (int i = 0; i < 96; i++)
        begin
            if (i == 10)
            begin
                hold_request = 1'b1;
            end
            send_pixel(pick_pixel());
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_random_frames();
        int start_count;
        int n;
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS)
        begin
            wait_until_drained();
            if ($urandom_range(0, 1) == 0)
            begin
                write_reg(REG_MODE, 32'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(REG_WIDTH, ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 2))
                                                                 : 32'($urandom_range(3, 16)));
            end
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       write_reg(REG_HEIGHT, 32'($urandom_range(0, 2)));
                    1:       write_reg(REG_HEIGHT, 32'($urandom_range(11, 2047)));
                    default: write_reg(REG_HEIGHT, 32'($urandom_range(3, 10)));
                endcase
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_HIGH_THR, 32'd0);
                    1:       write_reg(REG_HIGH_THR, 32'd255);
                    default: write_reg(REG_HIGH_THR, 32'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_LOW_THR, 32'd0);
                    1:       write_reg(REG_LOW_THR, 32'd255);
                    default: write_reg(REG_LOW_THR, 32'($urandom_range(0, 255)));
                endcase
            end
            n = $urandom_range(10, 150);
            for (int i = 0; i < n; i++)
            begin
                send_pixel(pick_pixel());
            end
        end
    endtask

    task automatic test_widest_frame();
        wait_until_drained();
        write_reg(REG_WIDTH, 32'd2047);
        write_reg(REG_HEIGHT, 32'd0);
        write_reg(REG_MODE, 32'($urandom_range(0, 1)));
        write_reg(REG_HIGH_THR, 32'($urandom_range(0, 255)));
        write_reg(REG_LOW_THR, 32'($urandom_range(0, 255)));
        for (int i = 0; i < CNM_MAX_WIDTH + WIDEST_EXTRA; i++)
        begin
            if (i == CNM_MAX_WIDTH + 40)
            begin
                hold_request = 1'b1;
            end
            send_pixel(pick_pixel());
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        in_pixel       = '0;
        mismatch_count = 0;
        sent_count     = 0;
        burst_left     = 0;
        no_gaps        = 1'b0;
        hold_request   = 1'b0;
        cycle_count    = 0;
        cfg_mode       = MODE_RESET;
        cfg_width      = WIDTH_RESET;
        cfg_height     = HEIGHT_RESET;
        cfg_high       = HIGH_THR_RESET;
        cfg_low        = LOW_THR_RESET;
        pos_col        = 0;
        pos_row        = 0;
        for (int i = 0; i < CNM_MAX_WIDTH; i++)
        begin
            line_prev[i]  = '0;
            line_prev2[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_saturated_grow_frame();
        test_restart_shrink_frame();
        test_backpressure();
        test_random_frames();
        test_widest_frame();

        wait_until_drained();
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("cross_neighbour_morphology verification clean");
        end
        else
        begin
            $display("cross_neighbour_morphology verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/cnm_pkg.sv
rtl/cnm_out_fifo.sv
rtl/cross_neighbour_morphology.sv
test/cross_neighbour_morphology_tb.sv
